>>> rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and command codes for the sorted interval set.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int MAX_RANGES = 16;
    localparam int TIME_BITS  = 32;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_CONTAINS = 2'd1,
        CMD_NEAREST  = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic scan;      // compare at scan index, advance
        logic merge;     // absorb scanned entry into the new range
        logic shift;     // move one tail entry to its new slot
        logic place;     // write merged range at insert position
        logic finish;    // build result, store count
        logic pop;       // result taken
    } sis_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // scan index reached count
        logic found;      // entry at scan index has end >= key
        logic overlap;    // entry at scan index overlaps new range
        logic full;       // add would overflow
        logic shift_done; // tail moved
        logic out_valid;
    } sis_stat_t;

endpackage

>>> rtl/sorted_interval_set.sv
// ----------------------------------------------------------------------------
// sorted_interval_set
// Sorted table of disjoint closed tick ranges with add, contains, nearest, read.
//
// channel  dir  fields
// s_axis   in   tdata: command, range_start, range_end, query_time, entry_index
// m_axis   out  tdata: hit, time_value, end_value, error, range_count
//
// One item at a time: a read goes straight to the result; contains and nearest
// scan the entries; add scans, merges overlapping entries, shifts the tail and
// places the new range, or stops after merging when refused.
// Every scan, merge and shift step touches one table entry per cycle.
// Reset clears the count and output valid; the tables need no clear.
// A stalled result holds the block; input is taken once it is delivered.
// ----------------------------------------------------------------------------
module sorted_interval_set
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], range_start[33:2], range_end[65:34], query_time[97:66],
    // entry_index[101:98]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], time_value[32:1], end_value[64:33], error[65], range_count[70:66]
    output logic [71:0]  m_axis_tdata
);

    localparam int CW = $clog2(sis_pkg::MAX_RANGES + 1);

    sis_pkg::sis_cmd_t  cmd;
    sis_pkg::sis_stat_t stat;
    logic                          o_hit, o_err;
    logic [sis_pkg::TIME_BITS-1:0] o_time, o_end;
    logic [CW-1:0]                 o_count;

    sis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tdata[1:0]),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sis_dp #(.MAX_RANGES(sis_pkg::MAX_RANGES), .TIME_BITS(sis_pkg::TIME_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (s_axis_tdata[1:0]),
        .in_start  (s_axis_tdata[33:2]),
        .in_end    (s_axis_tdata[65:34]),
        .in_time   (s_axis_tdata[97:66]),
        .in_index  (s_axis_tdata[101:98]),
        .cmd       (cmd),
        .stat      (stat),
        .out_hit   (o_hit),
        .out_time  (o_time),
        .out_end   (o_end),
        .out_error (o_err),
        .out_count (o_count)
    );

    assign m_axis_tvalid = stat.out_valid;
    assign m_axis_tdata  = {1'b0, 5'(o_count), o_err, 32'(o_end), 32'(o_time), o_hit};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[70:66] <= 5'(sis_pkg::MAX_RANGES)))
        else $error("range count above capacity");

    a_read_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[65]) |-> (m_axis_tdata[64:33] == '0))
        else $error("error result with nonzero end");

endmodule

>>> rtl/sis_ctrl.sv
// ----------------------------------------------------------------------------
// sis_ctrl
// Sequencer: search, merge, shift and place steps for one command at a time.
// ----------------------------------------------------------------------------
module sis_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    input  logic                out_ready,
    output logic                in_ready,
    output sis_pkg::sis_cmd_t   cmd,
    input  sis_pkg::sis_stat_t  stat
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FIND  = 6'b000010,
        ST_MERGE = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_PLACE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   is_add_reg, is_add_next;

    assign in_ready = (state_reg == ST_IDLE) && !stat.out_valid;

    always_comb
    begin
        state_next  = state_reg;
        is_add_next = is_add_reg;
        cmd         = '0;
        cmd.pop     = stat.out_valid && out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load    = 1'b1;
                    is_add_next = (in_cmd == sis_pkg::CMD_ADD);
                    state_next  = (in_cmd == sis_pkg::CMD_READ) ? ST_DONE : ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (stat.scan_done || stat.found)
                    state_next = is_add_reg ? ST_MERGE : ST_DONE;
                else
                    cmd.scan = 1'b1;
            end
            ST_MERGE:
            begin
                if (!stat.scan_done && stat.overlap)
                    cmd.merge = 1'b1;
                else if (stat.full)
                    state_next = ST_DONE;
                else
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (stat.shift_done)
                    state_next = ST_PLACE;
                else
                    cmd.shift = 1'b1;
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            is_add_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            is_add_reg <= is_add_next;
        end
    end

endmodule

>>> rtl/sis_dp.sv
// ----------------------------------------------------------------------------
// sis_dp
// Range tables, scan index, merge registers and the result register.
// ----------------------------------------------------------------------------
module sis_dp #(
    parameter int MAX_RANGES = 16,
    parameter int TIME_BITS  = 32,
    parameter int IW         = $clog2(MAX_RANGES),
    parameter int CW         = $clog2(MAX_RANGES + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           in_cmd,
    input  logic [TIME_BITS-1:0] in_start,
    input  logic [TIME_BITS-1:0] in_end,
    input  logic [TIME_BITS-1:0] in_time,
    input  logic [3:0]           in_index,
    input  sis_pkg::sis_cmd_t    cmd,
    output sis_pkg::sis_stat_t   stat,
    output logic                 out_hit,
    output logic [TIME_BITS-1:0] out_time,
    output logic [TIME_BITS-1:0] out_end,
    output logic                 out_error,
    output logic [CW-1:0]        out_count
);

    logic [TIME_BITS-1:0] starts_mem [MAX_RANGES];
    logic [TIME_BITS-1:0] ends_mem   [MAX_RANGES];

    logic [1:0]           op_reg;
    logic [TIME_BITS-1:0] s_reg, e_reg, t_reg;
    logic [3:0]           idx_reg;
    logic [CW-1:0]        count_reg, pos_reg, k_reg, src_reg;
    logic [TIME_BITS-1:0] prev_end_reg;
    logic                 valid_reg;
    logic [CW-1:0]        new_count;
    logic [CW-1:0]        dst;
    logic                 grow;
    logic [CW-1:0]        src_init, rd_idx;

    logic [TIME_BITS-1:0] cur_s, cur_e, key, dprev, dnext, near;
    logic                 in_rng, has_lb;

    assign cur_s  = starts_mem[k_reg[IW-1:0]];
    assign cur_e  = ends_mem[k_reg[IW-1:0]];
    assign key    = (op_reg == sis_pkg::CMD_ADD) ? s_reg : t_reg;
    assign has_lb = k_reg < count_reg;
    assign in_rng = has_lb && (cur_s <= t_reg) && (t_reg <= cur_e);
    assign dprev  = (t_reg >= prev_end_reg) ? t_reg - prev_end_reg : prev_end_reg - t_reg;
    assign dnext  = (cur_s >= t_reg) ? cur_s - t_reg : t_reg - cur_s;
    assign new_count = count_reg + CW'(1) - (k_reg - pos_reg);
    // grow: walk the tail top down; after a merge: walk it bottom up
    assign grow     = (k_reg == pos_reg);
    assign src_init = grow ? count_reg : k_reg;
    assign rd_idx   = grow ? src_reg - CW'(1) : src_reg;
    assign dst      = rd_idx - (k_reg - pos_reg) + CW'(1);

    always_comb
    begin
        stat            = '0;
        stat.scan_done  = !has_lb;
        stat.found      = has_lb && (cur_e >= key);
        stat.overlap    = (e_reg >= cur_s) && (s_reg <= cur_e);
        stat.full       = ({1'b0, new_count} > (CW+1)'(MAX_RANGES));
        stat.shift_done = grow ? (src_reg == k_reg) : (src_reg == count_reg);
        stat.out_valid  = valid_reg;
        if (count_reg == '0)
            near = '0;
        else if (!has_lb)
            near = prev_end_reg;
        else if (in_rng)
            near = t_reg;
        else if (k_reg == '0)
            near = cur_s;
        else
            near = (dprev <= dnext) ? prev_end_reg : cur_s;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            starts_mem[dst[IW-1:0]] <= starts_mem[rd_idx[IW-1:0]];
            ends_mem[dst[IW-1:0]]   <= ends_mem[rd_idx[IW-1:0]];
        end
        if (cmd.place)
        begin
            starts_mem[pos_reg[IW-1:0]] <= s_reg;
            ends_mem[pos_reg[IW-1:0]]   <= e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pop)
                valid_reg <= 1'b0;
            if (cmd.finish)
            begin
                valid_reg <= 1'b1;
                if (op_reg == sis_pkg::CMD_ADD && !stat.full)
                    count_reg <= new_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_cmd;
            s_reg        <= in_start;
            e_reg        <= in_end;
            t_reg        <= in_time;
            idx_reg      <= in_index;
            k_reg        <= '0;
            pos_reg      <= '0;
            prev_end_reg <= ends_mem[IW'(count_reg - CW'(1))];
        end
        if (cmd.scan)
        begin
            prev_end_reg <= cur_e;
            k_reg        <= k_reg + CW'(1);
            pos_reg      <= k_reg + CW'(1);
        end
        if (cmd.merge)
        begin
            if (cur_s < s_reg) s_reg <= cur_s;
            if (cur_e > e_reg) e_reg <= cur_e;
            k_reg <= k_reg + CW'(1);
            src_reg <= src_init;
        end
        else if (!cmd.scan && !cmd.load && !cmd.shift && !cmd.place && !cmd.finish)
            src_reg <= src_init;
        if (cmd.shift)
            src_reg <= grow ? src_reg - CW'(1) : src_reg + CW'(1);
        if (cmd.finish)
        begin
            out_hit   <= 1'b0;
            out_time  <= '0;
            out_end   <= '0;
            out_error <= 1'b0;
            out_count <= count_reg;
            case (op_reg)
                sis_pkg::CMD_ADD:
                begin
                    out_error <= stat.full;
                    if (!stat.full) out_count <= new_count;
                end
                sis_pkg::CMD_CONTAINS: out_hit  <= in_rng;
                sis_pkg::CMD_NEAREST:  out_time <= near;
                default:
                begin
                    if ({1'b0, idx_reg} < (CW+1)'(count_reg) && CW'(idx_reg) < count_reg)
                    begin
                        out_time <= starts_mem[IW'(idx_reg)];
                        out_end  <= ends_mem[IW'(idx_reg)];
                    end
                    else
                        out_error <= 1'b1;
                end
            endcase
        end
    end

endmodule
